// ===== src/fetl_pkg.sv =====
// ----------------------------------------------------------------------------
// fetl_pkg
// Shared types, constants and helpers of the file extension type lookup unit.
// ----------------------------------------------------------------------------
package fetl_pkg;

    // default sizes
    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int KEY_CHARS_DEF     = 10;

    // field widths
    localparam int OP_W    = 2;
    localparam int ENTRY_W = 6;
    localparam int POS_W   = 4;
    localparam int CHAR_W  = 8;
    localparam int LEN_W   = 4;
    localparam int CFG_W   = 7;

    // configuration port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic [ADDR_W-1:0] ADDR_ENTRIES_IN_USE = 3'd0;

    // separator of the extension
    localparam logic [CHAR_W-1:0] DOT_CHAR = 8'h2E;

    // item operation codes
    typedef enum logic [OP_W-1:0] {
        OP_KEY_CHAR  = 2'd0,
        OP_KEY_LEN   = 2'd1,
        OP_NAME_CHAR = 2'd2,
        OP_END_NAME  = 2'd3
    } t_op;

    // search token handed from cell to cell
    typedef struct packed {
        logic valid;
        logic eligible;
        logic hit;
    } t_token;

    // key table write, broadcast to all cells
    typedef struct packed {
        logic               char_en;
        logic               len_en;
        logic [ENTRY_W-1:0] entry;
        logic [POS_W-1:0]   pos;
        logic [CHAR_W-1:0]  chr;
        logic [LEN_W-1:0]   len;
    } t_key_wr;

    // map 'A'..'Z' to 'a'..'z', keep every other byte
    function automatic logic [CHAR_W-1:0] fetl_lower(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

// ===== src/fetl_item_if.sv =====
// ----------------------------------------------------------------------------
// fetl_item_if
// Input item channel: valid/ready handshake with the item fields.
// ----------------------------------------------------------------------------
interface fetl_item_if;
    logic                            valid;
    logic                            ready;
    logic [fetl_pkg::OP_W-1:0]       operation;
    logic [fetl_pkg::ENTRY_W-1:0]    entry_index;
    logic [fetl_pkg::POS_W-1:0]      char_position;
    logic [fetl_pkg::CHAR_W-1:0]     char_value;
    logic [fetl_pkg::LEN_W-1:0]      key_length;

    modport source (output valid, operation, entry_index, char_position, char_value,
                    key_length, input ready);
    modport sink (input valid, operation, entry_index, char_position, char_value,
                  key_length, output ready);
endinterface

// ===== src/fetl_result_if.sv =====
// ----------------------------------------------------------------------------
// fetl_result_if
// Result channel: valid/ready handshake with the lookup answer.
// ----------------------------------------------------------------------------
interface fetl_result_if;
    logic                          valid;
    logic                          ready;
    logic                          found;
    logic [fetl_pkg::ENTRY_W-1:0]  match_index;

    modport source (output valid, found, match_index, input ready);
    modport sink (input valid, found, match_index, output ready);
endinterface

// ===== src/fetl_ext.sv =====
// ----------------------------------------------------------------------------
// fetl_ext
// Extension collector: keeps the lower-cased characters after the last dot
// and, at the end of a name, freezes them and launches a search token.
// ----------------------------------------------------------------------------
module fetl_ext #(
    parameter int KEY_CHARS = fetl_pkg::KEY_CHARS_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_name_en,
    input  logic                                     i_end_en,
    input  logic [fetl_pkg::CHAR_W-1:0]              i_char,
    input  logic                                     i_adv,
    output fetl_pkg::t_token                         o_q_tok,
    output logic [KEY_CHARS-1:0][fetl_pkg::CHAR_W-1:0] o_q_chars,
    output logic [$clog2(KEY_CHARS+1)-1:0]           o_q_count
);
    localparam int CW = $clog2(KEY_CHARS + 1);

    logic [KEY_CHARS-1:0][fetl_pkg::CHAR_W-1:0] r_ext;
    logic [CW-1:0]                              r_count;
    logic                                       r_too_long;
    logic                                       r_dot_seen;
    logic [KEY_CHARS-1:0][fetl_pkg::CHAR_W-1:0] r_q_chars;
    logic [CW-1:0]                              r_q_count;
    fetl_pkg::t_token                           r_q_tok;
    logic [fetl_pkg::CHAR_W-1:0]                w_lc;
    logic                                       w_is_dot;
    logic                                       w_has_room;

    // lower-case the incoming character
    always_comb begin
        w_lc       = fetl_pkg::fetl_lower(i_char);
        w_is_dot   = (w_lc == fetl_pkg::DOT_CHAR);
        w_has_room = (32'(r_count) < KEY_CHARS);
    end

    // extension characters, written at the fill position
    always_ff @(posedge i_clk) begin
        if (i_name_en && !w_is_dot && w_has_room) begin
            for (int j = 0; j < KEY_CHARS; j++) begin
                if (CW'(j) == r_count) begin
                    r_ext[j] <= w_lc;
                end
            end
        end
    end

    // fill count and name flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_too_long <= 1'b0;
            r_dot_seen <= 1'b0;
        end else if (i_end_en) begin
            r_count    <= '0;
            r_too_long <= 1'b0;
            r_dot_seen <= 1'b0;
        end else if (i_name_en) begin
            if (w_is_dot) begin
                r_dot_seen <= 1'b1;
                r_count    <= '0;
                r_too_long <= 1'b0;
            end else if (w_has_room) begin
                r_count <= r_count + CW'(1);
            end else begin
                r_too_long <= 1'b1;
            end
        end
    end

    // frozen extension for the search
    always_ff @(posedge i_clk) begin
        if (i_end_en) begin
            r_q_chars <= r_ext;
            r_q_count <= r_count;
        end
    end

    // launch token, held until the first cell takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_tok <= '0;
        end else if (i_end_en) begin
            r_q_tok.valid    <= 1'b1;
            r_q_tok.eligible <= r_dot_seen && !r_too_long && (r_count != '0);
            r_q_tok.hit      <= 1'b0;
        end else if (i_adv) begin
            r_q_tok.valid <= 1'b0;
        end
    end

    assign o_q_tok   = r_q_tok;
    assign o_q_chars = r_q_chars;
    assign o_q_count = r_q_count;

endmodule

// ===== src/fetl_cell.sv =====
// ----------------------------------------------------------------------------
// fetl_cell
// One table entry: holds its key and length, compares them with the frozen
// extension as the search token passes and hands the token to the next cell.
// ----------------------------------------------------------------------------
module fetl_cell #(
    parameter int CELL_INDEX    = 0,
    parameter int TABLE_ENTRIES = fetl_pkg::TABLE_ENTRIES_DEF,
    parameter int KEY_CHARS     = fetl_pkg::KEY_CHARS_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_adv,
    input  fetl_pkg::t_key_wr                          i_wr,
    input  logic [$clog2(TABLE_ENTRIES+1)-1:0]         i_limit,
    input  logic [KEY_CHARS-1:0][fetl_pkg::CHAR_W-1:0] i_q_chars,
    input  logic [$clog2(KEY_CHARS+1)-1:0]             i_q_count,
    input  fetl_pkg::t_token                           i_tok,
    input  logic [((TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1)-1:0] i_idx,
    output fetl_pkg::t_token                           o_tok,
    output logic [((TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1)-1:0] o_idx
);
    localparam int CW = $clog2(KEY_CHARS + 1);
    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    logic [KEY_CHARS-1:0][fetl_pkg::CHAR_W-1:0] r_key;
    logic [CW-1:0]                              r_len;
    fetl_pkg::t_token                           r_tok;
    logic [IW-1:0]                              r_idx;
    fetl_pkg::t_token                           n_tok;
    logic [IW-1:0]                              n_idx;
    logic                                       w_sel;
    logic                                       w_key_eq;
    logic                                       w_hit;

    assign w_sel = (32'(i_wr.entry) == CELL_INDEX);

    // key characters, no reset
    always_ff @(posedge i_clk) begin
        if (i_wr.char_en && w_sel) begin
            for (int j = 0; j < KEY_CHARS; j++) begin
                if (32'(i_wr.pos) == j) begin
                    r_key[j] <= i_wr.chr;
                end
            end
        end
    end

    // key length, zero marks the entry unused
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else if (i_wr.len_en && w_sel) begin
            r_len <= (32'(i_wr.len) > KEY_CHARS) ? CW'(KEY_CHARS) : CW'(i_wr.len);
        end
    end

    // compare key with the frozen extension
    always_comb begin
        w_key_eq = (r_len == i_q_count);
        for (int j = 0; j < KEY_CHARS; j++) begin
            if ((CW'(j) < i_q_count) && (r_key[j] != i_q_chars[j])) begin
                w_key_eq = 1'b0;
            end
        end
        w_hit = i_tok.valid && i_tok.eligible && !i_tok.hit
                && (CELL_INDEX < 32'(i_limit)) && w_key_eq;
        n_tok     = i_tok;
        n_tok.hit = i_tok.hit | w_hit;
        n_idx     = w_hit ? IW'(CELL_INDEX) : i_idx;
    end

    // token stage toward the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else if (i_adv) begin
            r_tok <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_idx <= n_idx;
        end
    end

    assign o_tok = r_tok;
    assign o_idx = r_idx;

endmodule

// ===== src/file_extension_type_lookup_unit.sv =====
// ----------------------------------------------------------------------------
// file_extension_type_lookup_unit
// Extension key table with a per-name lookup of the lowest matching entry.
// ----------------------------------------------------------------------------
// Key writes, key lengths and name characters are taken one per cycle while
// no search is in flight. An end of name freezes the extension and sends a
// search token down a chain of TABLE_ENTRIES cells, one cell per cycle unless
// stalled, each cell holding one table entry; the answer enters the output
// register when the token leaves the last cell, and the next item is taken in
// the cycle after that, so an end of name occupies the input until its answer
// is registered. A result that is not taken stalls the whole chain where the
// token stands, and the input with it, until that result is transferred.
// entries_in_use lies at byte address 0 of the register port and saturates to
// TABLE_ENTRIES; write it only while no search is in flight.
module file_extension_type_lookup_unit #(
    parameter int TABLE_ENTRIES = fetl_pkg::TABLE_ENTRIES_DEF,
    parameter int KEY_CHARS     = fetl_pkg::KEY_CHARS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    fetl_item_if.sink                     i_item,
    fetl_result_if.source                 o_result,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [fetl_pkg::ADDR_W-1:0]   i_paddr,
    input  logic [fetl_pkg::DATA_W-1:0]   i_pwdata,
    output logic [fetl_pkg::DATA_W-1:0]   o_prdata,
    output logic                          o_pready
);
    localparam int CW    = $clog2(KEY_CHARS + 1);
    localparam int IW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int LIM_W = $clog2(TABLE_ENTRIES + 1);

    logic [fetl_pkg::CFG_W-1:0]                 r_entries;
    logic [LIM_W-1:0]                           w_limit;
    logic                                       r_busy;
    logic                                       r_out_valid;
    logic                                       r_out_found;
    logic [fetl_pkg::ENTRY_W-1:0]               r_out_idx;
    logic                                       w_accept;
    logic                                       w_name_en;
    logic                                       w_end_en;
    logic                                       w_adv;
    fetl_pkg::t_key_wr                          w_wr;
    fetl_pkg::t_token                           w_tok [TABLE_ENTRIES+1];
    logic [IW-1:0]                              w_idx [TABLE_ENTRIES+1];
    logic [TABLE_ENTRIES:0]                     w_tok_valids;
    logic [KEY_CHARS-1:0][fetl_pkg::CHAR_W-1:0] w_q_chars;
    logic [CW-1:0]                              w_q_count;

    // register port
    assign o_pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries <= '0;
        end else if (i_psel && i_penable && i_pwrite
                     && (i_paddr == fetl_pkg::ADDR_ENTRIES_IN_USE)) begin
            r_entries <= i_pwdata[fetl_pkg::CFG_W-1:0];
        end
    end

    assign o_prdata = (i_paddr == fetl_pkg::ADDR_ENTRIES_IN_USE)
                      ? fetl_pkg::DATA_W'(r_entries) : '0;

    // searched entry count, saturated to the table size
    assign w_limit = (32'(r_entries) > TABLE_ENTRIES) ? LIM_W'(TABLE_ENTRIES)
                                                     : LIM_W'(r_entries);

    // input transfer and operation decode
    assign i_item.ready = !r_busy;
    assign w_accept     = i_item.valid && !r_busy;
    assign w_name_en    = w_accept && (i_item.operation == fetl_pkg::OP_NAME_CHAR);
    assign w_end_en     = w_accept && (i_item.operation == fetl_pkg::OP_END_NAME);

    always_comb begin
        w_wr.char_en = w_accept && (i_item.operation == fetl_pkg::OP_KEY_CHAR);
        w_wr.len_en  = w_accept && (i_item.operation == fetl_pkg::OP_KEY_LEN);
        w_wr.entry   = i_item.entry_index;
        w_wr.pos     = i_item.char_position;
        w_wr.chr     = fetl_pkg::fetl_lower(i_item.char_value);
        w_wr.len     = i_item.key_length;
    end

    // chain moves whenever the output register can take a result
    assign w_adv = !r_out_valid || o_result.ready;

    fetl_ext #(
        .KEY_CHARS (KEY_CHARS)
    ) u_ext (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_name_en (w_name_en),
        .i_end_en  (w_end_en),
        .i_char    (i_item.char_value),
        .i_adv     (w_adv),
        .o_q_tok   (w_tok[0]),
        .o_q_chars (w_q_chars),
        .o_q_count (w_q_count)
    );

    assign w_idx[0] = '0;

    // row of table cells
    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cells
        fetl_cell #(
            .CELL_INDEX    (g),
            .TABLE_ENTRIES (TABLE_ENTRIES),
            .KEY_CHARS     (KEY_CHARS)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_adv     (w_adv),
            .i_wr      (w_wr),
            .i_limit   (w_limit),
            .i_q_chars (w_q_chars),
            .i_q_count (w_q_count),
            .i_tok     (w_tok[g]),
            .i_idx     (w_idx[g]),
            .o_tok     (w_tok[g+1]),
            .o_idx     (w_idx[g+1])
        );
    end

    for (genvar v = 0; v <= TABLE_ENTRIES; v++) begin : g_valids
        assign w_tok_valids[v] = w_tok[v].valid;
    end

    // search in flight from end of name until the answer is registered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_end_en) begin
            r_busy <= 1'b1;
        end else if (w_adv && w_tok[TABLE_ENTRIES].valid) begin
            r_busy <= 1'b0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_tok[TABLE_ENTRIES].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_tok[TABLE_ENTRIES].valid) begin
            r_out_found <= w_tok[TABLE_ENTRIES].hit;
            r_out_idx   <= w_tok[TABLE_ENTRIES].hit
                           ? fetl_pkg::ENTRY_W'(w_idx[TABLE_ENTRIES]) : '0;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.found       = r_out_found;
    assign o_result.match_index = r_out_idx;

    // only one search token anywhere in the chain
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_tok_valids) <= 1)
        else $error("more than one search token in the chain");

    // a token can only reach the end while a search is marked in flight
    a_token_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tok[TABLE_ENTRIES].valid |-> r_busy)
        else $error("search token without a search in flight");

    // a miss reports index zero
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_found) |-> (r_out_idx == '0))
        else $error("not-found result with nonzero index");

    // an end of name always yields a result register load later, never at once
    a_end_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_end_en |=> (r_busy && !w_tok[TABLE_ENTRIES].valid))
        else $error("end of name did not start a search");

endmodule
